// ===== design/sab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend package
// Register indexes, configuration port widths and the stage enable bundle.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE  = 3'd6;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} sab_stage_en_t;

endpackage

// ===== design/sab_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend input channel
// One sprite pixel, its background pixel and its place in the sprite.
// ----------------------------------------------------------------------------
interface sab_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_pixel;
	logic [23:0] dst_pixel;
	logic [11:0] col;
	logic [11:0] row;

	modport source (output valid, output src_pixel, output dst_pixel, output col,
		output row, input ready);
	modport sink (input valid, input src_pixel, input dst_pixel, input col,
		input row, output ready);
endinterface

// ===== design/sab_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend result channel
// Frame write address, blended pixel and write enable.
// ----------------------------------------------------------------------------
interface sab_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] address;
	logic [23:0] pixel_out;
	logic        write_enable;

	modport source (output valid, output address, output pixel_out,
		output write_enable, input ready);
	modport sink (input valid, input address, input pixel_out,
		input write_enable, output ready);
endinterface

// ===== design/sab_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend configuration channel
// Register write transfers: register index and write data.
// ----------------------------------------------------------------------------
interface sab_cfg_if;
	import sab_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/sab_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend colour pipeline
// Three stages: alpha fade product, channel products, divide by 255 and sum.
// ----------------------------------------------------------------------------
module sab_blend
	import sab_pkg::*;
(
	input  logic          clk,
	input  sab_stage_en_t en,
	input  logic [31:0]   src_pixel,
	input  logic [23:0]   dst_pixel,
	input  logic [8:0]    alpha_scale,
	output logic [23:0]   pixel_out
);

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	logic [16:0] alpha_prod_s1;
	logic [23:0] src_rgb_s1;
	logic [23:0] dst_rgb_s1;
	logic [7:0]  alpha;
	logic [15:0] src_prod_s2 [3];
	logic [15:0] dst_prod_s2 [3];

	assign alpha = alpha_prod_s1[16] ? 8'd255 : alpha_prod_s1[15:8];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			alpha_prod_s1 <= 17'(src_pixel[31:24] * alpha_scale);
			src_rgb_s1    <= src_pixel[23:0];
			dst_rgb_s1    <= dst_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < 3; k++) begin
				src_prod_s2[k] <= 16'(src_rgb_s1[8*k +: 8] * alpha);
				dst_prod_s2[k] <= 16'(dst_rgb_s1[8*k +: 8] * (8'd255 - alpha));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < 3; k++) begin
				pixel_out[8*k +: 8] <= div255(src_prod_s2[k]) + div255(dst_prod_s2[k]);
			end
		end
	end

endmodule

// ===== design/sprite_alpha_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend
// Composites ARGB sprite pixels over RGB frame pixels and gives write addresses.
// ----------------------------------------------------------------------------
// The block takes one pixel in every clock while its output is not stalled, and
// gives its result through a three-stage pipeline (alpha fade, channel
// and address multipliers, divide by 255 with the address add); a stalled
// output holds only the stages that carry a pixel, so bubbles inside the
// pipeline are filled from behind while nothing is lost or repeated.
// Configuration writes are taken at any time but must only be made while the
// pipeline is empty.
module sprite_alpha_blend
	import sab_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	sab_in_if.sink   pixel_in,
	sab_out_if.source pixel_res,
	sab_cfg_if.sink  cfg
);

	localparam int          DIM_CAP   = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
	localparam logic [12:0] DIM_CAP_V = 13'(DIM_CAP);

	logic [11:0] offset_x_q;
	logic [11:0] offset_y_q;
	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [12:0] sprite_width_q;
	logic        mirror_q;
	logic [8:0]  alpha_scale_q;

	logic [12:0] fw_c;
	logic [12:0] fh_c;
	logic [12:0] sw_c;

	sab_stage_en_t en;
	logic v_s1, v_s2, v_s3;

	logic [23:0] col_sel;
	logic [23:0] tx_s1;
	logic [12:0] ty_s1;
	logic        col_ok_s1;
	logic [25:0] addr_prod_s2;
	logic [23:0] tx_s2;
	logic        inside_s2;
	logic [23:0] address_s3;
	logic        we_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q     <= 12'd0;
			offset_y_q     <= 12'd0;
			frame_width_q  <= 13'd640;
			frame_height_q <= 13'd480;
			sprite_width_q <= 13'd64;
			mirror_q       <= 1'b0;
			alpha_scale_q  <= 9'd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_OFFSET_X:     offset_x_q     <= cfg.data[11:0];
				REG_OFFSET_Y:     offset_y_q     <= cfg.data[11:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data[12:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data[12:0];
				REG_SPRITE_WIDTH: sprite_width_q <= cfg.data[12:0];
				REG_MIRROR:       mirror_q       <= cfg.data[0];
				REG_ALPHA_SCALE:  alpha_scale_q  <= cfg.data[8:0];
				default: begin
				end
			endcase
		end
	end

	assign fw_c = (frame_width_q  > DIM_CAP_V) ? DIM_CAP_V : frame_width_q;
	assign fh_c = (frame_height_q > DIM_CAP_V) ? DIM_CAP_V : frame_height_q;
	assign sw_c = (sprite_width_q > DIM_CAP_V) ? DIM_CAP_V : sprite_width_q;

	assign en.s3 = !v_s3 || pixel_res.ready;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;
	assign pixel_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= pixel_in.valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// A mirrored column past the sprite edge wraps; col_ok_s1 clears its write enable.
	assign col_sel = mirror_q ? (24'(sw_c) - 24'd1 - 24'(pixel_in.col))
	                          : 24'(pixel_in.col);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			tx_s1     <= 24'(offset_x_q) + col_sel;
			ty_s1     <= 13'(offset_y_q) + 13'(pixel_in.row);
			col_ok_s1 <= !mirror_q || ({1'b0, pixel_in.col} < sw_c);
		end
		if (en.s2) begin
			addr_prod_s2 <= 26'(ty_s1 * fw_c);
			tx_s2        <= tx_s1;
			inside_s2    <= col_ok_s1 && (tx_s1 < 24'(fw_c)) && (ty_s1 < fh_c);
		end
		if (en.s3) begin
			address_s3 <= addr_prod_s2[23:0] + tx_s2;
			we_s3      <= inside_s2;
		end
	end

	sab_blend u_blend (
		.clk         (clk),
		.en          (en),
		.src_pixel   (pixel_in.src_pixel),
		.dst_pixel   (pixel_in.dst_pixel),
		.alpha_scale (alpha_scale_q),
		.pixel_out   (pixel_res.pixel_out)
	);

	assign pixel_res.valid        = v_s3;
	assign pixel_res.address      = address_s3;
	assign pixel_res.write_enable = we_s3;

endmodule

// ===== design/sab_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend checker
// Port-level properties of the pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module sab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_address,
	input logic [23:0] out_pixel,
	input logic        out_we
);

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	// A result waiting for transfer stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_address) && $stable(out_pixel)
			&& $stable(out_we))
		else $error("result payload changed while stalled");

	// A free output never holds back the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is free");

	// With the output free, an input transfer passes through the pipeline to the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer ##1 out_ready ##1 out_ready) |=> out_valid)
		else $error("pipeline latency exceeded");

endmodule

bind sprite_alpha_blend sab_checker u_sab_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixel_in.valid),
	.in_ready    (pixel_in.ready),
	.out_valid   (pixel_res.valid),
	.out_ready   (pixel_res.ready),
	.out_address (pixel_res.address),
	.out_pixel   (pixel_res.pixel_out),
	.out_we      (pixel_res.write_enable)
);

// ===== bench/tb_sprite_alpha_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite alpha blend testbench
// Streams sprite and background pixels through the blender under a series of
// register settings and traffic patterns. A bit-accurate predictor computes
// the faded alpha, the blended pixel, the frame address and the write enable
// for every accepted input transfer, and a monitor checks every result
// transfer against the oldest prediction. The register settings include the
// reset values, oversized and zero dimensions, a fade above one, mirroring
// past the sprite edge and address wrap-around.
// ----------------------------------------------------------------------------
module tb_sprite_alpha_blend;
	import sab_pkg::*;

	localparam int MAX_DIM         = 4096;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 110;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [2:0] {
		TM_FLOW,
		TM_SRC_IDLE,
		TM_SNK_STALL,
		TM_BOTH,
		TM_BACKLOG
	} traffic_mode_t;

	typedef struct packed {
		logic [31:0] src;
		logic [23:0] dst;
		logic [11:0] col;
		logic [11:0] row;
	} pix_item_t;

	typedef struct packed {
		logic [23:0] address;
		logic [23:0] pixel;
		logic        we;
	} blend_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid  = 1'b0;
	pix_item_t             in_item   = '0;
	logic                  res_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [11:0] cur_offx   = 12'd0;
	logic [11:0] cur_offy   = 12'd0;
	logic [12:0] cur_fw     = 13'd640;
	logic [12:0] cur_fh     = 13'd480;
	logic [12:0] cur_sw     = 13'd64;
	logic        cur_mirror = 1'b0;
	logic [8:0]  cur_alpha  = 9'd256;

	traffic_mode_t mode = TM_FLOW;
	pix_item_t     pix_pending[$];
	blend_res_t    blend_exp[$];
	blend_res_t    res_want;
	int            err_cnt      = 0;
	int            hold_cnt     = 0;
	int            quiet_cycles = 0;

	sab_in_if  pix_in_if();
	sab_out_if pix_res_if();
	sab_cfg_if cfg_bus();

	assign pix_in_if.valid     = in_valid;
	assign pix_in_if.src_pixel = in_item.src;
	assign pix_in_if.dst_pixel = in_item.dst;
	assign pix_in_if.col       = in_item.col;
	assign pix_in_if.row       = in_item.row;
	assign pix_res_if.ready    = res_ready;
	assign cfg_bus.valid       = cfg_valid;
	assign cfg_bus.index       = cfg_index;
	assign cfg_bus.data        = cfg_data;

	sprite_alpha_blend #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_in (pix_in_if),
		.pixel_res(pix_res_if),
		.cfg      (cfg_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic blend_res_t blend_predict(pix_item_t px);
		blend_res_t  res;
		int unsigned fw, fh, sw, sa, a, s, d, c, tx, ty;
		logic        col_ok;
		fw = (cur_fw > MAX_DIM) ? MAX_DIM : cur_fw;
		fh = (cur_fh > MAX_DIM) ? MAX_DIM : cur_fh;
		sw = (cur_sw > MAX_DIM) ? MAX_DIM : cur_sw;
		sa = px.src[31:24];
		a  = (sa * cur_alpha) >> 8;
		if (a > 255)
			a = 255;
		for (int k = 0; k < 3; k++) begin
			s = px.src[8*k +: 8];
			d = px.dst[8*k +: 8];
			res.pixel[8*k +: 8] = 8'((s * a) / 255 + (d * (255 - a)) / 255);
		end
		if (cur_mirror) begin
			col_ok = (px.col < sw);
			c      = sw - 1 - px.col;
		end else begin
			col_ok = 1'b1;
			c      = px.col;
		end
		tx = cur_offx + c;
		ty = cur_offy + px.row;
		res.address = 24'(ty * fw + tx);
		res.we      = col_ok && (tx < fw) && (ty < fh);
		return res;
	endfunction

	function automatic int src_idle_pct(traffic_mode_t m);
		case (m)
			TM_SRC_IDLE: return 87;
			TM_BOTH:     return 24;
			default:     return 0;
		endcase
	endfunction

	function automatic int snk_stall_pct(traffic_mode_t m);
		case (m)
			TM_SNK_STALL: return 87;
			TM_BOTH:      return 24;
			default:      return 0;
		endcase
	endfunction

	function automatic pix_item_t rand_pixel();
		pix_item_t   px;
		int unsigned sw, fh, lim, pick;
		sw = (cur_sw > MAX_DIM) ? MAX_DIM : cur_sw;
		fh = (cur_fh > MAX_DIM) ? MAX_DIM : cur_fh;
		px.src = $urandom();
		pick   = $urandom_range(9);
		if (pick == 0)
			px.src[31:24] = 8'h00;
		else if (pick == 1)
			px.src[31:24] = 8'hFF;
		else if (pick == 2)
			px.src = '1;
		px.dst = 24'($urandom());
		if ($urandom_range(15) == 0)
			px.dst = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(9) < 7) begin
			lim    = (sw + 1 > 4095) ? 4095 : sw + 1;
			px.col = 12'($urandom_range(lim));
			lim    = (fh > 4095) ? 4095 : fh;
			px.row = 12'($urandom_range(lim));
		end else begin
			px.col = 12'($urandom_range(4095));
			px.row = 12'($urandom_range(4095));
		end
		return px;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		int unsigned pick;
		pick = $urandom_range(19);
		if (pick < 2)
			return '0;
		else if (pick == 2)
			return 13'd4095;
		else if (pick < 15)
			return 13'($urandom_range(200));
		return 13'($urandom());
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim(int unsigned typical_max);
		case ($urandom_range(19))
			0:       return 13'd0;
			1:       return 13'd1;
			2:       return 13'd4096;
			3:       return 13'd8191;
			4:       return 13'($urandom_range(8191, 4097));
			default: return 13'($urandom_range(typical_max, 1));
		endcase
	endfunction

	// Starts on a rising edge and returns on the edge of the transfer, with
	// valid left high for a following write.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_OFFSET_X:     cur_offx   = val[11:0];
			REG_OFFSET_Y:     cur_offy   = val[11:0];
			REG_FRAME_WIDTH:  cur_fw     = val[12:0];
			REG_FRAME_HEIGHT: cur_fh     = val[12:0];
			REG_SPRITE_WIDTH: cur_sw     = val[12:0];
			REG_MIRROR:       cur_mirror = val[0];
			REG_ALPHA_SCALE:  cur_alpha  = val[8:0];
			default: ;
		endcase
	endtask

	task automatic cfg_set(logic [CFG_DATA_W-1:0] ox, logic [CFG_DATA_W-1:0] oy,
		logic [CFG_DATA_W-1:0] fw, logic [CFG_DATA_W-1:0] fh,
		logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] mir,
		logic [CFG_DATA_W-1:0] alpha);
		cfg_write(REG_OFFSET_X, ox);
		cfg_write(REG_OFFSET_Y, oy);
		cfg_write(REG_FRAME_WIDTH, fw);
		cfg_write(REG_FRAME_HEIGHT, fh);
		cfg_write(REG_SPRITE_WIDTH, sw);
		cfg_write(REG_MIRROR, mir);
		cfg_write(REG_ALPHA_SCALE, alpha);
		cfg_valid <= 1'b0;
	endtask

	task automatic cfg_shuffle();
		logic [CFG_DATA_W-1:0] alpha;
		case ($urandom_range(9)) inside
			0:       alpha = 13'd0;
			[1:2]:   alpha = 13'd256;
			3:       alpha = 13'd511;
			4:       alpha = 13'($urandom_range(511, 257));
			default: alpha = 13'($urandom_range(256));
		endcase
		if ($urandom_range(3) == 0)
			alpha[12:9] = 4'($urandom());
		cfg_set(pick_offset(), pick_offset(), pick_dim(700), pick_dim(500), pick_dim(128),
			13'($urandom()), alpha);
	endtask

	task automatic add_px(logic [31:0] src, logic [23:0] dst, logic [11:0] col,
		logic [11:0] row);
		pix_pending.push_back('{src: src, dst: dst, col: col, row: row});
	endtask

	task automatic start_phase(traffic_mode_t m);
		@(negedge clk);
		mode = m;
	endtask

	// Returns on a rising edge once the pipeline has emptied and settled.
	task automatic drain();
		do @(negedge clk); while (pix_pending.size() != 0 || in_valid || blend_exp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && pix_in_if.ready)
				blend_exp.push_back(blend_predict(in_item));
			if (!in_valid || pix_in_if.ready) begin
				if (pix_pending.size() != 0 && $urandom_range(99) >= src_idle_pct(mode)) begin
					in_item  <= pix_pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_res_if.valid && res_ready) begin
				if (blend_exp.size() == 0) begin
					$error("result transfer with no prediction pending");
					err_cnt++;
				end else begin
					res_want = blend_exp.pop_front();
					if (pix_res_if.address !== res_want.address) begin
						$error("address: expected %h, actual %h", res_want.address,
							pix_res_if.address);
						err_cnt++;
					end
					if (pix_res_if.pixel_out !== res_want.pixel) begin
						$error("pixel_out: expected %h, actual %h", res_want.pixel,
							pix_res_if.pixel_out);
						err_cnt++;
					end
					if (pix_res_if.write_enable !== res_want.we) begin
						$error("write_enable: expected %b, actual %b", res_want.we,
							pix_res_if.write_enable);
						err_cnt++;
					end
				end
			end
		end
	end

	// In backlog mode the receiver first holds off so that the pipeline fills.
	always @(posedge clk) begin
		if (arst_n) begin
			if (mode == TM_BACKLOG && hold_cnt < HOLD_CYCLES) begin
				hold_cnt  <= hold_cnt + 1;
				res_ready <= 1'b0;
			end else begin
				if (mode != TM_BACKLOG)
					hold_cnt <= 0;
				res_ready <= ($urandom_range(99) >= snk_stall_pct(mode));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && pix_in_if.ready) || (pix_res_if.valid && res_ready) ||
				(cfg_valid && cfg_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("[sprite_alpha_blend] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		start_phase(TM_FLOW);
		add_px(32'hFFFF_FFFF, 24'h000000, 12'd0, 12'd0);
		add_px(32'h00FF_FFFF, 24'hFFFFFF, 12'd4095, 12'd4095);
		add_px(32'h8012_3456, 24'hABCDEF, 12'd63, 12'd479);
		add_px(32'h7FC0_FFEE, 24'h102030, 12'd639, 12'd0);
		add_px(32'hFF55_AA00, 24'h00FF00, 12'd640, 12'd10);
		add_px(32'h01FE_01FE, 24'hFE01FE, 12'd5, 12'd480);
		add_px(32'hFE00_0000, 24'hFFFFFF, 12'd64, 12'd100);
		drain();

		cfg_set(13'd10, 13'd5, 13'd8191, 13'd8191, 13'd64, 13'd1, 13'd511);
		start_phase(TM_FLOW);
		add_px(32'h80FF_0000, 24'h00FFFF, 12'd0, 12'd0);
		add_px(32'h40AB_CDEF, 24'h123456, 12'd63, 12'd4095);
		add_px(32'hFFFF_FFFF, 24'h000000, 12'd64, 12'd7);
		add_px(32'h0000_0000, 24'hFFFFFF, 12'd4095, 12'd0);
		add_px(32'h1234_5678, 24'h9ABCDE, 12'd20, 12'd20);
		drain();

		cfg_write(REG_UNUSED, '1);
		cfg_set(13'd4095, 13'd4095, 13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0);
		start_phase(TM_FLOW);
		add_px(32'hFFFF_FFFF, 24'h5A5AA5, 12'd0, 12'd0);
		add_px(32'hC0C0_C0C0, 24'hA5A55A, 12'd1, 12'd0);
		add_px(32'hFF12_3456, 24'hFFFFFF, 12'd4095, 12'd4095);
		drain();

		cfg_set(13'd0, 13'd0, 13'd0, 13'd5, 13'd0, 13'd1, 13'd257);
		start_phase(TM_FLOW);
		add_px(32'hF0F0_F0F0, 24'h0F0F0F, 12'd0, 12'd0);
		add_px(32'h7777_7777, 24'h888888, 12'd3, 12'd2);
		drain();

		cfg_set(13'd3, 13'd0, 13'd100, 13'd0, 13'd4097, 13'd0, 13'd1);
		start_phase(TM_FLOW);
		add_px(32'hFFFF_FFFF, 24'h000000, 12'd0, 12'd0);
		add_px(32'hFF00_FF00, 24'hFF00FF, 12'd50, 12'd0);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			cfg_shuffle();
			start_phase(traffic_mode_t'(p % 5));
			repeat (ITEMS_PER_PHASE) pix_pending.push_back(rand_pixel());
			drain();
		end

		@(negedge clk);
		if (err_cnt == 0 && blend_exp.size() == 0)
			$display("[sprite_alpha_blend] OK");
		else
			$display("[sprite_alpha_blend] ERROR");
		$finish;
	end

endmodule
